### hdl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants for the streaming Harris corner unit.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int ColW      = $clog2(MaxWidth);

    localparam logic [8:0] ROW_MAX    = 9'd511;
    localparam logic [8:0] WIDTH_MIN  = 9'd5;
    localparam logic [8:0] WIDTH_MAX  = 9'(MaxWidth);
    localparam logic [8:0] HEIGHT_MAX = 9'(MaxHeight);

    // Gaussian weights, Q16
    localparam logic signed [17:0] W_CORNER = 18'sd24111;
    localparam logic signed [17:0] W_EDGE   = 18'sd39748;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_K_FACTOR   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

    typedef logic signed [10:0] grad_t;

    typedef struct packed {
        logic       win_valid;
        logic [7:0] cx;
        logic [7:0] cy;
    } meta_t;

endpackage

### hdl/hcs_line_mem.sv
// ----------------------------------------------------------------------------
// hcs_line_mem
// Four line stores packed as one word per column; read, patch, write back.
// ----------------------------------------------------------------------------
module hcs_line_mem import hcs_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            rd_en,
    input  logic [ColW-1:0] rd_addr,
    input  logic [1:0]      rd_sel,
    input  logic [7:0]      rd_pix,
    input  meta_t           rd_meta,
    output logic            col_valid,
    output meta_t           col_meta,
    output logic [7:0]      col_pix [5]
);

    logic [31:0]     mem [MaxWidth];
    logic [31:0]     rdata_reg;
    logic            v_reg;
    logic [ColW-1:0] addr_reg;
    logic [1:0]      sel_reg;
    logic [7:0]      pix_reg;
    meta_t           meta_reg;
    logic [31:0]     wdata;

    // Patch the byte of the current row
    always_comb begin
        wdata = rdata_reg;
        wdata[8*sel_reg +: 8] = pix_reg;
    end

    // Read with forwarding of the write-back to the same column
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (rd_en) begin
                if (v_reg && addr_reg == rd_addr) begin
                    rdata_reg <= wdata;
                end else begin
                    rdata_reg <= mem[rd_addr];
                end
            end
            if (v_reg) begin
                mem[addr_reg] <= wdata;
            end
            addr_reg <= rd_addr;
            sel_reg  <= rd_sel;
            pix_reg  <= rd_pix;
            meta_reg <= rd_meta;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (adv) begin
            v_reg <= rd_en;
        end
    end

    // Rotate stored rows into window order, oldest first
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            col_pix[r] = rdata_reg[8*(2'(sel_reg + 2'(r))) +: 8];
        end
        col_pix[4] = pix_reg;
    end

    assign col_valid = v_reg;
    assign col_meta  = meta_reg;

endmodule

### hdl/hcs_window_grad.sv
// ----------------------------------------------------------------------------
// hcs_window_grad
// 5x5 pixel window and Sobel gradients at the nine inner positions.
// ----------------------------------------------------------------------------
module hcs_window_grad import hcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       col_valid,
    input  meta_t      col_meta,
    input  logic [7:0] col_pix [5],
    output logic       g_valid,
    output meta_t      g_meta,
    output grad_t      gx [9],
    output grad_t      gy [9]
);

    logic [7:0] win_reg [5][5];
    logic       v2_reg, v3_reg;
    meta_t      meta2_reg, meta3_reg;
    grad_t      gx_reg [9];
    grad_t      gy_reg [9];
    grad_t      gx_next [9];
    grad_t      gy_next [9];

    function automatic grad_t px(input logic [7:0] p);
        px = grad_t'({3'b000, p});
    endfunction

    // Shift in the new column
    always_ff @(posedge aclk) begin
        if (adv && col_valid) begin
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 4; c++) begin
                    win_reg[r][c] <= win_reg[r][c+1];
                end
                win_reg[r][4] <= col_pix[r];
            end
        end
    end

    // Sobel at each inner position
    always_comb begin
        for (int r = 1; r <= 3; r++) begin
            for (int c = 1; c <= 3; c++) begin
                gx_next[(r-1)*3 + (c-1)] =
                    - px(win_reg[r-1][c-1]) - (px(win_reg[r][c-1]) <<< 1)
                    - px(win_reg[r+1][c-1]) + px(win_reg[r-1][c+1])
                    + (px(win_reg[r][c+1]) <<< 1) + px(win_reg[r+1][c+1]);
                gy_next[(r-1)*3 + (c-1)] =
                    - px(win_reg[r-1][c-1]) - (px(win_reg[r-1][c]) <<< 1)
                    - px(win_reg[r-1][c+1]) + px(win_reg[r+1][c-1])
                    + (px(win_reg[r+1][c]) <<< 1) + px(win_reg[r+1][c+1]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            meta2_reg <= col_meta;
            meta3_reg <= meta2_reg;
            for (int i = 0; i < 9; i++) begin
                gx_reg[i] <= gx_next[i];
                gy_reg[i] <= gy_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= col_valid;
            v3_reg <= v2_reg;
        end
    end

    assign g_valid = v3_reg;
    assign g_meta  = meta3_reg;
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            gx[i] = gx_reg[i];
            gy[i] = gy_reg[i];
        end
    end

endmodule

### hdl/hcs_response.sv
// ----------------------------------------------------------------------------
// hcs_response
// Weighted structure sums, Harris response, threshold and output register.
// ----------------------------------------------------------------------------
module hcs_response import hcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               g_valid,
    input  meta_t              g_meta,
    input  grad_t              gx [9],
    input  grad_t              gy [9],
    input  logic [15:0]        k_factor,
    input  logic [46:0]        threshold,
    output logic               out_valid,
    output logic               out_window_valid,
    output logic               out_corner,
    output logic [7:0]         out_centre_x,
    output logic [7:0]         out_centre_y,
    output logic signed [47:0] out_response
);

    localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000_0000;

    logic [9:4] v_reg;
    meta_t      m4_reg, m5_reg, m6_reg, m7_reg, m8_reg, m9_reg;

    logic signed [21:0] xx_reg [9];
    logic signed [21:0] yy_reg [9];
    logic signed [21:0] xy_reg [9];
    logic signed [23:0] cx_reg, ex_reg, mx_reg;
    logic signed [23:0] cy_reg, ey_reg, my_reg;
    logic signed [23:0] cxy_reg, exy_reg, mxy_reg;
    logic signed [25:0] sx2_reg, sy2_reg, sxy_reg;
    logic signed [51:0] p_reg, q_reg;
    logic [47:0]        trsq_reg;
    logic signed [52:0] diff_reg;
    logic [39:0]        klo_reg, khi_reg;
    logic signed [47:0] resp_reg;

    logic signed [41:0] ax, ay, axy;
    logic signed [26:0] tr;
    logic [63:0]        kterm;
    logic signed [65:0] resp_full;
    logic signed [47:0] resp_next;

    function automatic logic signed [41:0] wsum(input logic signed [23:0] c,
                                                input logic signed [23:0] e,
                                                input logic signed [23:0] m);
        wsum = c * W_CORNER + e * W_EDGE + (42'(m) <<< 16);
    endfunction

    assign ax  = wsum(cx_reg, ex_reg, mx_reg);
    assign ay  = wsum(cy_reg, ey_reg, my_reg);
    assign axy = wsum(cxy_reg, exy_reg, mxy_reg);
    assign tr  = 27'(sx2_reg) + 27'(sy2_reg);
    assign kterm = ({24'd0, khi_reg} << 24) + {24'd0, klo_reg};
    assign resp_full = 66'(diff_reg) - $signed({2'b00, kterm >> 16});

    // Saturate to the signed 48-bit range
    always_comb begin
        if (resp_full > SAT_MAX) begin
            resp_next = SAT_MAX[47:0];
        end else if (resp_full < SAT_MIN) begin
            resp_next = SAT_MIN[47:0];
        end else begin
            resp_next = resp_full[47:0];
        end
    end

    // Datapath stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 9; i++) begin
                xx_reg[i] <= gx[i] * gx[i];
                yy_reg[i] <= gy[i] * gy[i];
                xy_reg[i] <= gx[i] * gy[i];
            end
            cx_reg  <= 24'(xx_reg[0]) + 24'(xx_reg[2]) + 24'(xx_reg[6]) + 24'(xx_reg[8]);
            ex_reg  <= 24'(xx_reg[1]) + 24'(xx_reg[3]) + 24'(xx_reg[5]) + 24'(xx_reg[7]);
            mx_reg  <= 24'(xx_reg[4]);
            cy_reg  <= 24'(yy_reg[0]) + 24'(yy_reg[2]) + 24'(yy_reg[6]) + 24'(yy_reg[8]);
            ey_reg  <= 24'(yy_reg[1]) + 24'(yy_reg[3]) + 24'(yy_reg[5]) + 24'(yy_reg[7]);
            my_reg  <= 24'(yy_reg[4]);
            cxy_reg <= 24'(xy_reg[0]) + 24'(xy_reg[2]) + 24'(xy_reg[6]) + 24'(xy_reg[8]);
            exy_reg <= 24'(xy_reg[1]) + 24'(xy_reg[3]) + 24'(xy_reg[5]) + 24'(xy_reg[7]);
            mxy_reg <= 24'(xy_reg[4]);
            // floor by arithmetic shift
            sx2_reg  <= ax[41:16];
            sy2_reg  <= ay[41:16];
            sxy_reg  <= axy[41:16];
            p_reg    <= sx2_reg * sy2_reg;
            q_reg    <= sxy_reg * sxy_reg;
            trsq_reg <= tr[23:0] * tr[23:0];
            diff_reg <= 53'(p_reg) - 53'(q_reg);
            klo_reg  <= k_factor * trsq_reg[23:0];
            khi_reg  <= k_factor * trsq_reg[47:24];
            resp_reg <= resp_next;
            m4_reg <= g_meta;
            m5_reg <= m4_reg;
            m6_reg <= m5_reg;
            m7_reg <= m6_reg;
            m8_reg <= m7_reg;
            m9_reg <= m8_reg;
            // output register
            out_window_valid <= m9_reg.win_valid;
            out_centre_x     <= m9_reg.cx;
            out_centre_y     <= m9_reg.cy;
            out_response     <= m9_reg.win_valid ? resp_reg : '0;
            out_corner       <= m9_reg.win_valid &&
                                (50'(resp_reg) > $signed({3'b000, threshold}));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end else if (adv) begin
            v_reg     <= {v_reg[8:4], g_valid};
            out_valid <= v_reg[9];
        end
    end

endmodule

### hdl/harris_corner_stream_unit.sv
// ----------------------------------------------------------------------------
// harris_corner_stream_unit
// Streaming Harris corner detector on 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  pixel   | s_valid s_ready s_pixel s_frame_start   | in
//  result  | m_valid m_ready m_window_valid m_corner | out
//          | m_centre_x m_centre_y m_response        |
//  config  | cfg_wr_en cfg_index cfg_wr_data         | in
//
// One item per cycle sustained while the result is not stalled.
// The line store word is read at accept and written back from the patched read register,
// with forwarding when consecutive items hit the same column.
// The whole pipeline advances together; a stalled result holds every stage.
// Reset clears counters and valid bits; line and window contents are not cleared.
module harris_corner_stream_unit import hcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_pixel,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_window_valid,
    output logic               m_corner,
    output logic [7:0]         m_centre_x,
    output logic [7:0]         m_centre_y,
    output logic signed [47:0] m_response,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [46:0]        cfg_wr_data
);

    logic [8:0]  line_width_reg;
    logic [15:0] k_factor_reg;
    logic [46:0] threshold_reg;
    logic [7:0]  column_count_reg;
    logic [8:0]  row_count_reg;

    logic        adv, accept, valid;
    logic [8:0]  w, col, row;
    meta_t       in_meta;

    logic        col_valid, g_valid;
    meta_t       col_meta, g_meta;
    logic [7:0]  col_pix [5];
    grad_t       gx [9];
    grad_t       gy [9];

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // Clamp width and position the item
    always_comb begin
        if (line_width_reg < WIDTH_MIN) begin
            w = WIDTH_MIN;
        end else if (line_width_reg > WIDTH_MAX) begin
            w = WIDTH_MAX;
        end else begin
            w = line_width_reg;
        end
        col   = s_frame_start ? 9'd0 : {1'b0, column_count_reg};
        row   = s_frame_start ? 9'd0 : row_count_reg;
        valid = col >= 9'd4 && col < w && row >= 9'd4 && row < HEIGHT_MAX;
        in_meta.win_valid = valid;
        in_meta.cx = valid ? 8'(col - 9'd2) : 8'd0;
        in_meta.cy = valid ? 8'(row - 9'd2) : 8'd0;
    end

    // Advance raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else if (accept) begin
            if (col + 9'd1 >= w) begin
                column_count_reg <= '0;
                row_count_reg    <= (row < ROW_MAX) ? row + 9'd1 : row;
            end else begin
                column_count_reg <= 8'(col + 9'd1);
                row_count_reg    <= row;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= 9'd189;
            k_factor_reg   <= 16'd2621;
            threshold_reg  <= 47'd5000000000;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_LINE_WIDTH: line_width_reg <= cfg_wr_data[8:0];
                CFG_K_FACTOR:   k_factor_reg   <= cfg_wr_data[15:0];
                CFG_THRESHOLD:  threshold_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    hcs_line_mem u_line_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .rd_en     (accept),
        .rd_addr   (col[ColW-1:0]),
        .rd_sel    (row[1:0]),
        .rd_pix    (s_pixel),
        .rd_meta   (in_meta),
        .col_valid (col_valid),
        .col_meta  (col_meta),
        .col_pix   (col_pix)
    );

    hcs_window_grad u_window_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .col_valid (col_valid),
        .col_meta  (col_meta),
        .col_pix   (col_pix),
        .g_valid   (g_valid),
        .g_meta    (g_meta),
        .gx        (gx),
        .gy        (gy)
    );

    hcs_response u_response (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .adv              (adv),
        .g_valid          (g_valid),
        .g_meta           (g_meta),
        .gx               (gx),
        .gy               (gy),
        .k_factor         (k_factor_reg),
        .threshold        (threshold_reg),
        .out_valid        (m_valid),
        .out_window_valid (m_window_valid),
        .out_corner       (m_corner),
        .out_centre_x     (m_centre_x),
        .out_centre_y     (m_centre_y),
        .out_response     (m_response)
    );

`ifndef NO_ASSERTIONS
    a_corner_needs_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_corner |-> m_window_valid)
        else $error("corner flagged outside a valid window");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_valid |->
            m_response == 48'sd0 && m_centre_x == 8'd0 && m_centre_y == 8'd0)
        else $error("invalid window carries nonzero fields");
    a_centre_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_window_valid |-> m_centre_x >= 8'd2 && m_centre_y >= 8'd2)
        else $error("centre too close to the border");
`endif

endmodule

### bench/harris_corner_stream_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// harris_corner_stream_unit_tb
// Self-checking bench: streams pixel frames under random burst/stall timing,
// predicts every result with an in-bench Harris window model and compares
// each result field by field in arrival order.
// ----------------------------------------------------------------------------
module harris_corner_stream_unit_tb;
    import hcs_pkg::*;

    typedef struct {
        logic              wv;
        logic              corner;
        logic [7:0]        cx;
        logic [7:0]        cy;
        logic signed [47:0] resp;
    } corner_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_pixel = '0;
    logic               s_frame_start = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_window_valid;
    logic               m_corner;
    logic [7:0]         m_centre_x;
    logic [7:0]         m_centre_y;
    logic signed [47:0] m_response;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [46:0]        cfg_wr_data = '0;

    harris_corner_stream_unit dut (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic [7:0]  lines [4*MaxWidth];
    logic [7:0]  win [5][5];
    int unsigned col_cnt, row_cnt;
    int unsigned lw_reg = 189;
    int unsigned k_reg = 2621;
    logic [46:0] thr_reg = 47'd5000000000;

    corner_result_t expected_q[$];
    bit failed = 0;
    bit rx_hold = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int unsigned sent_count = 0;

    function automatic longint floor_div16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint harris_resp();
        longint ax = 0, ay = 0, axy = 0, gx, gy, w, sx2, sy2, sxy, tr, r_v;
        longint unsigned kt;
        int d;
        for (int r = 1; r <= 3; r++) begin
            for (int c = 1; c <= 3; c++) begin
                gx = -longint'(win[r-1][c-1]) - 2*win[r][c-1] - win[r+1][c-1]
                     + win[r-1][c+1] + 2*win[r][c+1] + win[r+1][c+1];
                gy = -longint'(win[r-1][c-1]) - 2*win[r-1][c] - win[r-1][c+1]
                     + win[r+1][c-1] + 2*win[r+1][c] + win[r+1][c+1];
                d = (r == 2 ? 0 : 1) + (c == 2 ? 0 : 1);
                w = d == 0 ? 65536 : (d == 1 ? 39748 : 24111);
                ax += w*gx*gx;
                ay += w*gy*gy;
                axy += w*gx*gy;
            end
        end
        sx2 = floor_div16(ax);
        sy2 = floor_div16(ay);
        sxy = floor_div16(axy);
        tr = sx2 + sy2;
        kt = (longint'(k_reg) * longint'(tr*tr)) >> 16;
        r_v = sx2*sy2 - sxy*sxy - longint'(kt);
        if (r_v > 64'sd140737488355327) r_v = 64'sd140737488355327;
        if (r_v < -64'sd140737488355328) r_v = -64'sd140737488355328;
        return r_v;
    endfunction

    // advance the predictor by one pixel and queue its result
    task automatic predict_pixel(input logic [7:0] pix, input logic fs);
        int unsigned w, col, row;
        corner_result_t res;
        longint rv;
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        w = lw_reg < 5 ? 5 : (lw_reg > MaxWidth ? MaxWidth : lw_reg);
        col = col_cnt > MaxWidth - 1 ? MaxWidth - 1 : col_cnt;
        row = row_cnt;
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 4; c++) win[r][c] = win[r][c+1];
        for (int r = 0; r < 4; r++) win[r][4] = lines[((row + r) & 3) * MaxWidth + col];
        win[4][4] = pix;
        lines[(row & 3) * MaxWidth + col] = pix;
        res = '{1'b0, 1'b0, 8'd0, 8'd0, 48'sd0};
        if (col >= 4 && col < w && row >= 4 && row < MaxHeight) begin
            rv = harris_resp();
            res.wv = 1'b1;
            res.corner = rv > longint'({17'd0, thr_reg});
            res.cx = 8'(col - 2);
            res.cy = 8'(row - 2);
            res.resp = rv[47:0];
        end
        expected_q.insert(expected_q.size(), res);
        if (col + 1 >= w) begin
            col_cnt = 0;
            if (row_cnt < 511) row_cnt++;
        end else begin
            col_cnt = col + 1;
        end
    endtask

    // send one item; bursts with random gaps
    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_pixel <= pix;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(pix, fs);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [46:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LINE_WIDTH: lw_reg = val[8:0];
            CFG_K_FACTOR:   k_reg = val[15:0];
            default:        thr_reg = val;
        endcase
    endtask

    // send a frame of given height; kind picks the pixel pattern
    task automatic send_frame(input int unsigned rows, input int kind);
        int unsigned w;
        logic [7:0] p;
        w = lw_reg < 5 ? 5 : (lw_reg > MaxWidth ? MaxWidth : lw_reg);
        for (int unsigned y = 0; y < rows; y++) begin
            for (int unsigned x = 0; x < w; x++) begin
                case (kind)
                    0: p = ((x >= w/2) ^ (y >= rows/2)) ? 8'hFF : 8'h00;
                    1: p = (x + y) % 2 ? 8'hFF : 8'h00;
                    default: p = 8'($urandom);
                endcase
                send_pixel(p, x == 0 && y == 0);
            end
        end
    endtask

    task automatic test_directed();
        write_reg(CFG_LINE_WIDTH, 47'd5);
        write_reg(CFG_K_FACTOR, 47'd0);
        write_reg(CFG_THRESHOLD, 47'd0);
        send_frame(5, 0);
        wait_drained();
        write_reg(CFG_K_FACTOR, 47'd65535);
        write_reg(CFG_THRESHOLD, {47{1'b1}});
        send_frame(4, 1);
        wait_drained();
    endtask

    task automatic test_checker_corners();
        write_reg(CFG_LINE_WIDTH, 47'd12);
        write_reg(CFG_K_FACTOR, 47'd2621);
        write_reg(CFG_THRESHOLD, 47'd5000000000);
        send_frame(10, 0);
        send_frame(8, 1);
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps pushing
    task automatic test_backpressure();
        write_reg(CFG_LINE_WIDTH, 47'd9);
        fork
            begin
                rx_hold = 1;
                repeat (200) @(posedge aclk);
                rx_hold = 0;
            end
            send_frame(8, 2);
        join
        wait_drained();
    endtask

    task automatic test_random_frames();
        int unsigned w;
        bit wide_done;
        wide_done = 0;
        while (sent_count < 800) begin
            case ($urandom_range(0, 3))
                0: write_reg(CFG_LINE_WIDTH, 47'($urandom_range(5, 16)));
                1: begin
                    if (!wide_done) begin
                        write_reg(CFG_LINE_WIDTH, 47'($urandom_range(257, 511)));
                        wide_done = 1;
                    end else begin
                        write_reg(CFG_LINE_WIDTH, 47'($urandom_range(0, 4)));
                    end
                end
                default: write_reg(CFG_LINE_WIDTH, 47'($urandom_range(5, 10)));
            endcase
            write_reg(CFG_K_FACTOR, 47'($urandom_range(0, 65535)));
            write_reg(CFG_THRESHOLD,
                      $urandom_range(0, 1) ? 47'($urandom_range(0, 1 << 30))
                                           : {15'($urandom), $urandom});
            w = lw_reg < 5 ? 5 : (lw_reg > MaxWidth ? MaxWidth : lw_reg);
            if (w <= 16) begin
                send_frame($urandom_range(5, 9), $urandom_range(0, 2));
            end else begin
                send_frame(1, 2);
            end
            wait_drained();
        end
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (rx_hold) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 3) != 0) || ($time / 4000) % 3 == 0;
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        corner_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result resp=%0d", $time, m_response);
                failed = 1;
            end else begin
                e = expected_q.pop_front();
                if (m_window_valid !== e.wv || m_corner !== e.corner ||
                    m_centre_x !== e.cx || m_centre_y !== e.cy || m_response !== e.resp) begin
                    $display("%0t: expected wv=%0b c=%0b x=%0d y=%0d r=%0d", $time,
                             e.wv, e.corner, e.cx, e.cy, e.resp);
                    $display("%0t: actual   wv=%0b c=%0b x=%0d y=%0d r=%0d", $time,
                             m_window_valid, m_corner, m_centre_x, m_centre_y, m_response);
                    failed = 1;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item or result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        foreach (lines[i]) lines[i] = '0;
        foreach (win[r, c]) win[r][c] = '0;
        col_cnt = 0;
        row_cnt = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_checker_corners();
        test_backpressure();
        test_random_frames();
        wait_drained();
        if (!failed) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
